@@ hdl/pmpe_pkg.sv @@
// ----------------------------------------------------------------------------
// pmpe_pkg
// Shared constants and types for the plus/minus/parenthesis evaluator.
// ----------------------------------------------------------------------------
package pmpe_pkg;

    localparam int NEST_DEPTH = 16;
    localparam int LEVEL_W    = $clog2(NEST_DEPTH + 1);
    localparam int ADDR_W     = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int DATA_W     = 32;
    localparam int CHAR_W     = 8;
    localparam int FRAME_W    = DATA_W + 1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2b;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CHAR_RPAREN = 8'h29;

    // stack frame: saved sum and saved sign
    typedef struct packed {
        logic              sign_neg;
        logic [DATA_W-1:0] sum;
    } frame_t;

    // decoded word waiting for the execute step
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
        logic              push_ok;
        logic              pop_ok;
        logic              stack_err;
        logic              unclosed;
        logic [ADDR_W-1:0] push_addr;
        logic              fwd_hit;
        frame_t            fwd_frame;
    } stage_t;

endpackage

@@ hdl/pmpe_char_if.sv @@
// ----------------------------------------------------------------------------
// pmpe_char_if
// Character channel: one ASCII character and a last flag per word.
// ----------------------------------------------------------------------------
interface pmpe_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

@@ hdl/pmpe_result_if.sv @@
// ----------------------------------------------------------------------------
// pmpe_result_if
// Result channel: expression value and error flag per word.
// ----------------------------------------------------------------------------
interface pmpe_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               error_flag;

    modport source (output valid, output result_value, output error_flag, input ready);
    modport sink   (input valid, input result_value, input error_flag, output ready);
endinterface

@@ hdl/pmpe_ram.sv @@
// ----------------------------------------------------------------------------
// pmpe_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pmpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/plus_minus_paren_evaluator_core.sv @@
// ----------------------------------------------------------------------------
// plus_minus_paren_evaluator_core
// Streaming evaluator for expressions with plus, minus and parentheses.
//
// chars carries one ASCII character per word with is_last marking the end of
// an expression. results carries one word per expression: the 32-bit wrapped
// value and an error flag for stack overflow, underflow or open parentheses.
// Digits, signs and unknown characters are consumed; '(' and ')' push and pop
// a sum/sign frame held in a synchronous RAM of NEST_DEPTH entries.
// Throughput is one character per cycle unless a held result stalls a last
// character. A character is decoded and the stack RAM read at acceptance and
// executed from the decode register, which feeds the registered result word.
// A push followed at once by a pop of the same entry is served by forwarding
// the written frame around the RAM read port.
// While a result word is stalled, non-last characters keep flowing; a further
// last character waits in the execute stage until the result is taken.
// Reset clears the level, sum, sign and error state; the stack RAM is not
// cleared, since an entry is only used by a pop after it was pushed.
// ----------------------------------------------------------------------------
module plus_minus_paren_evaluator_core (
    input  logic clk,
    input  logic rst_n,
    pmpe_char_if.sink     chars,
    pmpe_result_if.source results
);
    import pmpe_pkg::*;

    // decode stage
    logic               s1_valid_reg, s1_valid_next;
    stage_t             s1_reg, s1_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    // execute state
    logic [DATA_W-1:0]  number_reg, number_next;
    logic [DATA_W-1:0]  sum_reg, sum_next;
    logic               sign_reg, sign_next;
    logic               err_reg, err_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_value_reg, out_value_next;
    logic               out_err_reg, out_err_next;

    logic               accept;
    logic               exec;
    logic               is_lparen, is_rparen;
    logic               can_push, can_pop;
    logic [LEVEL_W-1:0] level_dec;
    logic [ADDR_W-1:0]  rd_addr;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    frame_t             ram_wframe;
    logic [FRAME_W-1:0] ram_rdata;
    frame_t             pop_frame;

    logic               is_digit;
    logic [DATA_W-1:0]  digit_val;
    logic [DATA_W-1:0]  num_acc;
    logic [DATA_W-1:0]  term;
    logic [DATA_W-1:0]  sum_fold;
    logic [DATA_W-1:0]  inner;

    // ---------------------------------------------------------------- decode
    assign exec   = s1_valid_reg && (!s1_reg.is_last || !out_valid_reg || results.ready);
    assign accept = chars.valid && chars.ready;
    assign chars.ready = !s1_valid_reg || exec;

    assign is_lparen = (chars.char_code == CHAR_LPAREN);
    assign is_rparen = (chars.char_code == CHAR_RPAREN);
    assign can_push  = (level_reg < LEVEL_W'(NEST_DEPTH));
    assign can_pop   = (level_reg != '0);
    assign level_dec = level_reg - LEVEL_W'(1);
    assign rd_addr   = level_dec[ADDR_W-1:0];

    always_comb
    begin
        level_next = level_reg;
        if (accept)
        begin
            if (is_lparen && can_push)
            begin
                level_next = level_reg + LEVEL_W'(1);
            end
            else if (is_rparen && can_pop)
            begin
                level_next = level_dec;
            end
        end
    end

    always_comb
    begin
        s1_next           = s1_reg;
        s1_valid_next     = s1_valid_reg;
        if (exec)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next       = 1'b1;
            s1_next.char_code   = chars.char_code;
            s1_next.is_last     = chars.is_last;
            s1_next.push_ok     = is_lparen && can_push;
            s1_next.pop_ok      = is_rparen && can_pop;
            s1_next.stack_err   = (is_lparen && !can_push) || (is_rparen && !can_pop);
            s1_next.unclosed    = (level_next != '0);
            s1_next.push_addr   = level_reg[ADDR_W-1:0];
            // push being written this cycle lands on the entry we read
            s1_next.fwd_hit     = ram_we && (ram_waddr == rd_addr);
            s1_next.fwd_frame   = ram_wframe;
        end
    end

    // --------------------------------------------------------------- execute
    assign pop_frame = s1_reg.fwd_hit ? s1_reg.fwd_frame : frame_t'(ram_rdata);
    assign is_digit  = (s1_reg.char_code >= CHAR_ZERO) && (s1_reg.char_code <= CHAR_NINE);
    assign digit_val = DATA_W'(s1_reg.char_code - CHAR_ZERO);
    assign num_acc   = (number_reg << 3) + (number_reg << 1) + digit_val;

    always_comb
    begin
        if (is_digit)
        begin
            term = sign_reg ? (DATA_W'(0) - num_acc) : num_acc;
        end
        else
        begin
            term = sign_reg ? (DATA_W'(0) - number_reg) : number_reg;
        end
    end

    assign sum_fold = sum_reg + term;
    assign inner    = pop_frame.sign_neg ? (DATA_W'(0) - sum_fold) : sum_fold;

    assign ram_we              = exec && s1_reg.push_ok;
    assign ram_waddr           = s1_reg.push_addr;
    assign ram_wframe.sum      = sum_fold;
    assign ram_wframe.sign_neg = sign_reg;

    always_comb
    begin
        number_next = number_reg;
        sum_next    = sum_reg;
        sign_next   = sign_reg;
        err_next    = err_reg;
        if (exec)
        begin
            err_next = err_reg || s1_reg.stack_err;
            if (is_digit)
            begin
                if (s1_reg.is_last)
                begin
                    sum_next    = sum_fold;
                    number_next = '0;
                end
                else
                begin
                    number_next = num_acc;
                end
            end
            else
            begin
                number_next = '0;
                sum_next    = sum_fold;
                case (s1_reg.char_code)
                    CHAR_PLUS:
                    begin
                        sign_next = 1'b0;
                    end
                    CHAR_MINUS:
                    begin
                        sign_next = 1'b1;
                    end
                    CHAR_LPAREN:
                    begin
                        if (s1_reg.push_ok)
                        begin
                            sum_next  = '0;
                            sign_next = 1'b0;
                        end
                    end
                    CHAR_RPAREN:
                    begin
                        if (s1_reg.pop_ok)
                        begin
                            sum_next = pop_frame.sum + inner;
                        end
                    end
                    default:
                    begin
                        sum_next = sum_fold;
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- output
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (exec && s1_reg.is_last)
        begin
            out_valid_next = 1'b1;
            out_value_next = sum_next;
            out_err_next   = err_next || s1_reg.unclosed;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.result_value = $signed(out_value_reg);
    assign results.error_flag   = out_err_reg;

    // ------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            level_reg     <= '0;
            number_reg    <= '0;
            sum_reg       <= '0;
            sign_reg      <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            // a finished expression returns the level and execute state to reset
            if (accept && chars.is_last)
            begin
                level_reg <= '0;
            end
            else
            begin
                level_reg <= level_next;
            end
            if (exec && s1_reg.is_last)
            begin
                number_reg <= '0;
                sum_reg    <= '0;
                sign_reg   <= 1'b0;
                err_reg    <= 1'b0;
            end
            else
            begin
                number_reg <= number_next;
                sum_reg    <= sum_next;
                sign_reg   <= sign_next;
                err_reg    <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg        <= s1_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    // ------------------------------------------------------------ stack RAM
    pmpe_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (NEST_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (FRAME_W'(ram_wframe)),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

endmodule
